FILE: design/lrk_pkg.sv
`default_nettype none

package lrk_pkg;

  // Data format: signed state and coefficients, fixed 32-bit word
  localparam int DATA_W = 32;
  // Time is a wider signed word with the same fraction
  localparam int TIME_W = 48;
  // Step count width
  localparam int CNT_W = 32;
  // Step size register width (unsigned)
  localparam int DT_W = 17;
  // Weighted sum of four stage increments needs three guard bits
  localparam int ACC_W = DATA_W + 3;
  // Default number of fraction bits
  localparam int FRAC_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA,
    REG_RHO,
    REG_BETA,
    REG_STEP_SIZE,
    REG_INIT_X,
    REG_INIT_Y,
    REG_INIT_Z,
    REG_INIT_TIME
  } reg_idx_t;

  // Register reset values
  localparam logic [DATA_W-1:0] SIGMA_RST     = DATA_W'(655360);
  localparam logic [DATA_W-1:0] RHO_RST       = DATA_W'(1835008);
  localparam logic [DATA_W-1:0] BETA_RST      = DATA_W'(174763);
  localparam logic [DT_W-1:0]   STEP_SIZE_RST = DT_W'(655);
  localparam logic [DATA_W-1:0] INIT_X_RST    = DATA_W'(65536);
  localparam logic [DATA_W-1:0] INIT_Y_RST    = '0;
  localparam logic [DATA_W-1:0] INIT_Z_RST    = '0;
  localparam logic [TIME_W-1:0] INIT_TIME_RST = '0;

  // Configuration bundle handed to the core
  typedef struct packed {
    logic [DATA_W-1:0] sigma;
    logic [DATA_W-1:0] rho;
    logic [DATA_W-1:0] beta;
    logic [DT_W-1:0]   step_size;
    logic [DATA_W-1:0] init_x;
    logic [DATA_W-1:0] init_y;
    logic [DATA_W-1:0] init_z;
    logic [TIME_W-1:0] init_time;
  } cfg_t;

  // Core status toward the handshake logic
  typedef struct packed {
    logic busy;
    logic emit;
  } core_stat_t;

endpackage

`default_nettype wire

FILE: design/lrk_mul.sv
`default_nettype none

module lrk_mul import lrk_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0]      res,
  output logic                          ovf
);

  localparam int PROD_W = 2 * DATA_W;
  localparam logic [PROD_W:0] RND     = (PROD_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W:0] LIM_NEG = (PROD_W+1)'(1) << (DATA_W - 1);
  localparam logic [PROD_W:0] LIM_POS = LIM_NEG - (PROD_W+1)'(1);

  logic [DATA_W-1:0] mag_a, mag_b;
  logic [PROD_W-1:0] prod;
  logic              neg;
  logic [PROD_W:0]   rsum, quo, lim, clipped;
  logic [DATA_W-1:0] qmag;

  // Take magnitudes; the most negative word maps to its unsigned magnitude
  assign mag_a = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
  assign mag_b = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;

  // Register the magnitude product and its sign
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= mag_a * mag_b;
      neg  <= a[DATA_W-1] ^ b[DATA_W-1];
    end
  end

  // Round half away from zero, drop fraction, clip, restore sign
  always_comb begin
    rsum    = {1'b0, prod} + RND;
    quo     = rsum >> FRAC_BITS;
    lim     = neg ? LIM_NEG : LIM_POS;
    ovf     = quo > lim;
    clipped = ovf ? lim : quo;
    qmag    = clipped[DATA_W-1:0];
    res     = neg ? (~qmag + DATA_W'(1)) : qmag;
  end

endmodule

`default_nettype wire

FILE: design/lrk_div6.sv
`default_nettype none

module lrk_div6 import lrk_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [ACC_W-1:0] sum,
  output logic                         done,
  output logic signed [ACC_W-1:0]      quot
);

  localparam int DIVISOR = 6;
  localparam int HALF_DIVISOR = DIVISOR / 2;
  localparam int RADIX_W = 4;
  localparam int DIGITS = (ACC_W + RADIX_W - 1) / RADIX_W;
  localparam int DIV_W = DIGITS * RADIX_W;
  localparam int REM_W = $clog2(DIVISOR);
  localparam int T_W = REM_W + RADIX_W;
  localparam int CNT_BITS = $clog2(DIGITS + 1);

  logic [ACC_W-1:0]   mag;
  logic [DIV_W-1:0]   num, quo;
  logic [REM_W-1:0]   rem;
  logic               neg;
  logic [CNT_BITS-1:0] cnt;
  logic [T_W-1:0]     t;
  logic [RADIX_W-1:0] qd;
  logic [T_W-1:0]     rem_next;

  // Quotient digit of a narrow partial remainder
  function automatic logic [RADIX_W-1:0] digit(input logic [T_W-1:0] v);
    logic [RADIX_W-1:0] d;
    d = '0;
    for (int i = 1; i < (1 << RADIX_W); i++) begin
      if (v >= T_W'(DIVISOR * i)) d = RADIX_W'(i);
    end
    return d;
  endfunction

  assign mag = sum[ACC_W-1] ? (~sum + ACC_W'(1)) : sum;

  // One radix-16 digit of long division per cycle
  always_comb begin
    t        = {rem, num[DIV_W-1 -: RADIX_W]};
    qd       = digit(t);
    rem_next = t - T_W'(qd) * T_W'(DIVISOR);
  end

  // Load, iterate, flag the last digit
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_BITS'(DIGITS);
        num <= DIV_W'(mag) + DIV_W'(HALF_DIVISOR);
        rem <= '0;
        quo <= '0;
        neg <= sum[ACC_W-1];
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_BITS'(1);
        num <= num << RADIX_W;
        rem <= rem_next[REM_W-1:0];
        quo <= {quo[DIV_W-RADIX_W-1:0], qd};
        if (cnt == CNT_BITS'(1)) done <= 1'b1;
      end
    end
  end

  assign quot = neg ? (~quo[ACC_W-1:0] + ACC_W'(1)) : quo[ACC_W-1:0];

endmodule

`default_nettype wire

FILE: design/lrk_core.sv
`default_nettype none

module lrk_core import lrk_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        start,
  input  wire logic        restart,
  input  wire logic        out_free,
  output core_stat_t       stat,
  output logic [DATA_W-1:0] cur_x,
  output logic [DATA_W-1:0] cur_y,
  output logic [DATA_W-1:0] cur_z,
  output logic [TIME_W-1:0] cur_time,
  output logic [CNT_W-1:0]  step_counter,
  output logic              clip
);

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_LAST_DERIV = PC_W'(10);
  localparam logic [PC_W-1:0] PC_LAST = PC_W'(13);
  localparam int STAGES = 4;
  localparam logic [1:0] STAGE_FIRST = 2'(0);
  localparam logic [1:0] STAGE_LAST = 2'(STAGES - 1);
  localparam logic [1:0] STAGE_FULL = 2'(STAGES - 2);

  localparam logic signed [ACC_W:0] D_MAX =
    {{(ACC_W-DATA_W+2){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] D_MIN =
    {{(ACC_W-DATA_W+2){1'b1}}, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MULW, S_DIVS, S_DIVW, S_DONE} state_t;
  typedef enum logic [1:0] {OP_SUB, OP_ADDK, OP_MUL} op_t;
  typedef enum logic [3:0] {
    SRC_SX, SRC_SY, SRC_SZ, SRC_T0, SRC_T1, SRC_SIGMA, SRC_RHO, SRC_BETA,
    SRC_DT, SRC_CX, SRC_CY, SRC_CZ, SRC_KX, SRC_KY, SRC_KZ
  } src_t;
  typedef enum logic [2:0] {
    DST_T0, DST_T1, DST_KX, DST_KY, DST_KZ, DST_SX, DST_SY, DST_SZ
  } dst_t;
  typedef enum logic [1:0] {C_X, C_Y, C_Z} coord_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t dst;
  } uop_t;

  // Microprogram of one stage: derivatives scaled by dt, then next stage input
  function automatic uop_t uop_at(input logic [PC_W-1:0] p);
    uop_t u;
    unique case (p)
      PC_W'(0):  u = '{OP_SUB,  SRC_SY,    SRC_SX, DST_T0};
      PC_W'(1):  u = '{OP_MUL,  SRC_SIGMA, SRC_T0, DST_T0};
      PC_W'(2):  u = '{OP_MUL,  SRC_DT,    SRC_T0, DST_KX};
      PC_W'(3):  u = '{OP_SUB,  SRC_RHO,   SRC_SZ, DST_T0};
      PC_W'(4):  u = '{OP_MUL,  SRC_SX,    SRC_T0, DST_T0};
      PC_W'(5):  u = '{OP_SUB,  SRC_T0,    SRC_SY, DST_T0};
      PC_W'(6):  u = '{OP_MUL,  SRC_DT,    SRC_T0, DST_KY};
      PC_W'(7):  u = '{OP_MUL,  SRC_SX,    SRC_SY, DST_T0};
      PC_W'(8):  u = '{OP_MUL,  SRC_BETA,  SRC_SZ, DST_T1};
      PC_W'(9):  u = '{OP_SUB,  SRC_T0,    SRC_T1, DST_T0};
      PC_W'(10): u = '{OP_MUL,  SRC_DT,    SRC_T0, DST_KZ};
      PC_W'(11): u = '{OP_ADDK, SRC_CX,    SRC_KX, DST_SX};
      PC_W'(12): u = '{OP_ADDK, SRC_CY,    SRC_KY, DST_SY};
      PC_W'(13): u = '{OP_ADDK, SRC_CZ,    SRC_KZ, DST_SZ};
      default:   u = '{OP_SUB,  SRC_SX,    SRC_SX, DST_T0};
    endcase
    return u;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_d(input logic signed [ACC_W:0] v);
    if (v > D_MAX) return D_MAX[DATA_W-1:0];
    if (v < D_MIN) return D_MIN[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  function automatic logic ovf_d(input logic signed [ACC_W:0] v);
    return (v > D_MAX) || (v < D_MIN);
  endfunction

  // Weights 1, 2, 2, 1 over the four stages
  function automatic logic signed [ACC_W-1:0] acc_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [DATA_W-1:0] k,
    input logic [1:0]               stg
  );
    logic signed [ACC_W-1:0] ke;
    ke = {{(ACC_W-DATA_W){k[DATA_W-1]}}, k};
    if (stg == STAGE_FIRST) return ke;
    if (stg == STAGE_LAST) return acc + ke;
    return acc + (ke <<< 1);
  endfunction

  state_t state;
  logic [PC_W-1:0] pc;
  logic [1:0] stage;
  coord_t coord;
  logic signed [DATA_W-1:0] sx, sy, sz, t0, t1, kx, ky, kz;
  logic signed [ACC_W-1:0] accx, accy, accz;

  uop_t uop;
  logic signed [DATA_W-1:0] opa, opb, bk, dt_word;
  logic signed [DATA_W:0] alu_sum;
  logic signed [ACC_W:0] alu_wide;
  logic signed [DATA_W-1:0] alu_res, mul_res, wb_val, cur_sel, upd_val;
  logic alu_ovf, mul_ovf, wb_en, wb_ovf, adv_div, upd_ovf, t_ovf;
  logic mul_en, div_start, div_done;
  logic signed [ACC_W-1:0] div_sum, div_quot;
  logic signed [ACC_W:0] upd_sum;
  logic [TIME_W:0] nt;

  assign uop = uop_at(pc);
  assign dt_word = {{(DATA_W-DT_W){1'b0}}, cfg.step_size};

  // Select operand A
  always_comb begin
    case (uop.a)
      SRC_SX:    opa = sx;
      SRC_SY:    opa = sy;
      SRC_SZ:    opa = sz;
      SRC_T0:    opa = t0;
      SRC_T1:    opa = t1;
      SRC_SIGMA: opa = cfg.sigma;
      SRC_RHO:   opa = cfg.rho;
      SRC_BETA:  opa = cfg.beta;
      SRC_DT:    opa = dt_word;
      SRC_CX:    opa = cur_x;
      SRC_CY:    opa = cur_y;
      SRC_CZ:    opa = cur_z;
      SRC_KX:    opa = kx;
      SRC_KY:    opa = ky;
      SRC_KZ:    opa = kz;
      default:   opa = sx;
    endcase
  end

  // Select operand B
  always_comb begin
    case (uop.b)
      SRC_SX:    opb = sx;
      SRC_SY:    opb = sy;
      SRC_SZ:    opb = sz;
      SRC_T0:    opb = t0;
      SRC_T1:    opb = t1;
      SRC_SIGMA: opb = cfg.sigma;
      SRC_RHO:   opb = cfg.rho;
      SRC_BETA:  opb = cfg.beta;
      SRC_DT:    opb = dt_word;
      SRC_CX:    opb = cur_x;
      SRC_CY:    opb = cur_y;
      SRC_CZ:    opb = cur_z;
      SRC_KX:    opb = kx;
      SRC_KY:    opb = ky;
      SRC_KZ:    opb = kz;
      default:   opb = sx;
    endcase
  end

  // Saturating add/subtract; stage inputs take half of k before the last stage
  always_comb begin
    bk = (stage < STAGE_FULL) ? (opb >>> 1) : opb;
    if (uop.op == OP_SUB) begin
      alu_sum = {opa[DATA_W-1], opa} - {opb[DATA_W-1], opb};
    end else begin
      alu_sum = {opa[DATA_W-1], opa} + {bk[DATA_W-1], bk};
    end
    alu_wide = {{(ACC_W-DATA_W){alu_sum[DATA_W]}}, alu_sum};
    alu_res  = sat_d(alu_wide);
    alu_ovf  = ovf_d(alu_wide);
  end

  assign mul_en = (state == S_EXEC) && (uop.op == OP_MUL);

  lrk_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .en (mul_en),
    .a  (opa),
    .b  (opb),
    .res(mul_res),
    .ovf(mul_ovf)
  );

  // Write back from the adder, or from the multiplier's registered product in S_MULW
  assign wb_en  = ((state == S_EXEC) && (uop.op != OP_MUL)) || (state == S_MULW);
  assign wb_val = (state == S_MULW) ? mul_res : alu_res;
  assign wb_ovf = (state == S_MULW) ? mul_ovf : alu_ovf;
  assign adv_div = (pc == PC_LAST_DERIV) && (stage == STAGE_LAST);

  // Pick the coordinate under final update
  always_comb begin
    case (coord)
      C_X:     begin cur_sel = cur_x; div_sum = accx; end
      C_Y:     begin cur_sel = cur_y; div_sum = accy; end
      C_Z:     begin cur_sel = cur_z; div_sum = accz; end
      default: begin cur_sel = cur_x; div_sum = accx; end
    endcase
  end

  assign div_start = (state == S_DIVS);

  lrk_div6 u_div6 (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .sum  (div_sum),
    .done (div_done),
    .quot (div_quot)
  );

  // New state value and advanced time
  always_comb begin
    upd_sum = {{(ACC_W+1-DATA_W){cur_sel[DATA_W-1]}}, cur_sel}
            + {div_quot[ACC_W-1], div_quot};
    upd_val = sat_d(upd_sum);
    upd_ovf = ovf_d(upd_sum);
    nt      = {cur_time[TIME_W-1], cur_time} + {{(TIME_W+1-DT_W){1'b0}}, cfg.step_size};
    t_ovf   = nt[TIME_W] != nt[TIME_W-1];
  end

  // Sequencer and register file
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pc           <= '0;
      stage        <= '0;
      coord        <= C_X;
      cur_x        <= '0;
      cur_y        <= '0;
      cur_z        <= '0;
      cur_time     <= '0;
      step_counter <= '0;
      clip         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            clip <= 1'b0;
            if (restart) begin
              cur_x        <= cfg.init_x;
              cur_y        <= cfg.init_y;
              cur_z        <= cfg.init_z;
              cur_time     <= cfg.init_time;
              step_counter <= '0;
              state        <= S_DONE;
            end else begin
              sx    <= cur_x;
              sy    <= cur_y;
              sz    <= cur_z;
              pc    <= '0;
              stage <= STAGE_FIRST;
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (uop.op == OP_MUL) state <= S_MULW;
        end
        S_MULW: begin
        end
        S_DIVS: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            if (upd_ovf || ((coord == C_Z) && t_ovf)) clip <= 1'b1;
            case (coord)
              C_X:     cur_x <= upd_val;
              C_Y:     cur_y <= upd_val;
              default: cur_z <= upd_val;
            endcase
            if (coord == C_Z) begin
              step_counter <= step_counter + CNT_W'(1);
              if (t_ovf) begin
                cur_time <= {1'b0, {(TIME_W-1){1'b1}}};
              end else begin
                cur_time <= nt[TIME_W-1:0];
              end
              state <= S_DONE;
            end else begin
              coord <= coord_t'(coord + 2'(1));
              state <= S_DIVS;
            end
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // Write the destination, accumulate k, advance the program
      if (wb_en) begin
        if (wb_ovf) clip <= 1'b1;
        case (uop.dst)
          DST_T0: t0 <= wb_val;
          DST_T1: t1 <= wb_val;
          DST_KX: begin kx <= wb_val; accx <= acc_add(accx, wb_val, stage); end
          DST_KY: begin ky <= wb_val; accy <= acc_add(accy, wb_val, stage); end
          DST_KZ: begin kz <= wb_val; accz <= acc_add(accz, wb_val, stage); end
          DST_SX: sx <= wb_val;
          DST_SY: sy <= wb_val;
          DST_SZ: sz <= wb_val;
          default: t0 <= wb_val;
        endcase
        if (adv_div) begin
          coord <= C_X;
          state <= S_DIVS;
        end else if (pc == PC_LAST) begin
          pc    <= '0;
          stage <= stage + 2'(1);
          state <= S_EXEC;
        end else begin
          pc    <= pc + PC_W'(1);
          state <= S_EXEC;
        end
      end
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.emit = (state == S_DONE) && out_free;

endmodule

`default_nettype wire

FILE: design/lorenz_rk4_step.sv
`default_nettype none

// Lorenz system integrator: each accepted item either reloads x, y, z and
// time from the init registers (restart high) or advances the state by one
// fourth-order Runge-Kutta step of size step_size, and produces one result.
// Values are signed fixed point with FRAC_BITS fraction bits, time is 48
// bits wide; every clip at the format limit raises saturated. A restart
// goes straight to the result; in_stall stays high from acceptance until
// the result sits in the output register. Step time is set by the shared
// multiplier (28 products, each registered between issue and write-back,
// plus 25 adds) and by the radix-16 divide-by-six unit, which forms nine
// digits for each of the three coordinates. Configuration writes are
// always ready; the user must keep them to idle periods (not enforced).
module lorenz_rk4_step import lrk_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  restart,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [DATA_W-1:0]   pos_x,
  output logic signed [DATA_W-1:0]   pos_y,
  output logic signed [DATA_W-1:0]   pos_z,
  output logic signed [TIME_W-1:0]   elapsed,
  output logic [CNT_W-1:0]           steps_done,
  output logic                       saturated,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  core_stat_t stat;
  logic in_accept, out_free;
  logic [DATA_W-1:0] core_x, core_y, core_z;
  logic [TIME_W-1:0] core_time;
  logic [CNT_W-1:0] core_count;
  logic core_clip;

  assign cfg_ready = 1'b1;

  // Hold configuration registers; writes take the low bits of the data
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sigma     <= SIGMA_RST;
      cfg.rho       <= RHO_RST;
      cfg.beta      <= BETA_RST;
      cfg.step_size <= STEP_SIZE_RST;
      cfg.init_x    <= INIT_X_RST;
      cfg.init_y    <= INIT_Y_RST;
      cfg.init_z    <= INIT_Z_RST;
      cfg.init_time <= INIT_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SIGMA:     cfg.sigma     <= cfg_data[DATA_W-1:0];
        REG_RHO:       cfg.rho       <= cfg_data[DATA_W-1:0];
        REG_BETA:      cfg.beta      <= cfg_data[DATA_W-1:0];
        REG_STEP_SIZE: cfg.step_size <= cfg_data[DT_W-1:0];
        REG_INIT_X:    cfg.init_x    <= cfg_data[DATA_W-1:0];
        REG_INIT_Y:    cfg.init_y    <= cfg_data[DATA_W-1:0];
        REG_INIT_Z:    cfg.init_z    <= cfg_data[DATA_W-1:0];
        REG_INIT_TIME: cfg.init_time <= cfg_data[TIME_W-1:0];
        default:       cfg.sigma     <= cfg.sigma;
      endcase
    end
  end

  // Accept an item only while the core is idle
  assign in_stall  = stat.busy;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  lrk_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start       (in_accept),
    .restart     (restart),
    .out_free    (out_free),
    .stat        (stat),
    .cur_x       (core_x),
    .cur_y       (core_y),
    .cur_z       (core_z),
    .cur_time    (core_time),
    .step_counter(core_count),
    .clip        (core_clip)
  );

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      pos_x      <= core_x;
      pos_y      <= core_y;
      pos_z      <= core_z;
      elapsed    <= core_time;
      steps_done <= core_count;
      saturated  <= core_clip;
    end
  end

`ifndef SYNTHESIS
  // An accepted item keeps the core busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("core idle right after accepting an item");

  // The core never overwrites a result still waiting downstream
  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    stat.emit |-> (!out_valid || !out_stall))
    else $error("result emitted over a pending result");

  // A restart with an empty output register is delivered the next cycle
  a_restart_fast: assert property (@(posedge clk) disable iff (rst)
    (in_accept && restart && !out_valid) |=> stat.emit)
    else $error("restart result not emitted in one cycle");
`endif

endmodule

`default_nettype wire
